@@ rtl/arsp_pkg.sv @@
// Shared types, constants and CRC helpers for the activity record stream parser.
// No dependencies.
package arsp_pkg;

	localparam int LOCAL_TYPES      = 16;
	localparam int TYPE_W           = 4;
	localparam int DEF_MAX_FIELDS   = 64;
	localparam int QDEPTH           = 2;
	localparam logic [3:0] HDR_CRC_END = 4'd12;
	localparam logic [3:0] HDR_LAST    = 4'd13;
	localparam logic [7:0] DEF_THRESH  = 8'd64;

	localparam logic [15:0] NIB_TAB [16] = '{
		16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
		16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
	};

	typedef enum logic [2:0] {
		PH_HEADER, PH_RECORD, PH_DEFINE, PH_FIELD, PH_SKIP, PH_TRAIL_LO, PH_TRAIL_HI, PH_IDLE
	} phase_t;

	typedef enum logic [1:0] {KIND_FIELD, KIND_HDR, KIND_FILE, KIND_ERR} kind_t;
	typedef enum logic [1:0] {ERR_NONE, ERR_UNDEF, ERR_COUNT} err_t;

	typedef struct packed {
		logic [7:0]        data;
		logic              start;
		logic              is_def;
		logic [TYPE_W-1:0] ltype;
	} qitem_t;

	function automatic logic [15:0] crc_half(logic [15:0] c, logic [3:0] n);
		return {4'h0, c[15:4]} ^ NIB_TAB[c[3:0]] ^ NIB_TAB[n];
	endfunction

	function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
		return crc_half(crc_half(c, b[3:0]), b[7:4]);
	endfunction

endpackage

@@ rtl/arsp_if.sv @@
// Valid/ready channel interfaces for parser input bytes and results.
// No dependencies.
interface arsp_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;
	modport source(output valid, data_byte, file_start, input ready);
	modport sink(input valid, data_byte, file_start, output ready);
endinterface

interface arsp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [15:0] message_number;
	logic [7:0]  field_number;
	logic [3:0]  local_type;
	logic [31:0] field_value;
	logic        check_ok;
	logic [1:0]  error_code;
	modport source(output valid, result_kind, message_number, field_number, local_type,
		field_value, check_ok, error_code, input ready);
	modport sink(input valid, result_kind, message_number, field_number, local_type,
		field_value, check_ok, error_code, output ready);
endinterface

@@ rtl/arsp_front.sv @@
// Front end: accepts input bytes and classifies record headers.
// Depends on arsp_pkg and arsp_if.
module arsp_front (
	input  logic             clk,
	input  logic             arst_n,
	arsp_item_if.sink        item,
	output arsp_pkg::qitem_t q_data,
	output logic             q_valid,
	input  logic             q_ready
);
	import arsp_pkg::*;

	qitem_t item_s1;
	logic   valid_s1;

	assign item.ready = !valid_s1 || q_ready;
	assign q_data     = item_s1;
	assign q_valid    = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.data   <= item.data_byte;
			item_s1.start  <= item.file_start;
			item_s1.is_def <= item.data_byte >= DEF_THRESH;
			item_s1.ltype  <= item.data_byte[TYPE_W-1:0];
		end
	end

endmodule

@@ rtl/arsp_queue.sv @@
// Short queue between front and back ends.
// Depends on arsp_pkg.
module arsp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  arsp_pkg::qitem_t wr_data,
	input  logic             wr_valid,
	output logic             wr_ready,
	output arsp_pkg::qitem_t rd_data,
	output logic             rd_valid,
	input  logic             rd_ready
);
	import arsp_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	qitem_t        mem_q [QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign wr_ready = cnt_q != (PW+1)'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_data;
	end

endmodule

@@ rtl/arsp_back.sv @@
// Back end: header/trailer CRC checks, type table, field extraction, result register.
// Depends on arsp_pkg and arsp_if.
module arsp_back #(
	parameter int MAX_FIELDS = arsp_pkg::DEF_MAX_FIELDS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  arsp_pkg::qitem_t qd,
	input  logic             q_valid,
	output logic             pop,
	arsp_result_if.source    result
);
	import arsp_pkg::*;

	localparam int DEPTH = LOCAL_TYPES * MAX_FIELDS;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [AW-1:0] slot(logic [TYPE_W-1:0] t, logic [7:0] f);
		return AW'(32'(t) * 32'(MAX_FIELDS) + 32'(f));
	endfunction

	phase_t      phase_q, phase_n;
	logic [3:0]  hpos_q, hpos_n;
	logic [31:0] dlen_q, dlen_n, left_q, left_n, acc_q, acc_n;
	logic [15:0] crc_q, crc_n, pmsg_q, pmsg_n;
	logic [7:0]  crclo_q, crclo_n, fi_q, fi_n, fbi_q, fbi_n;
	logic [2:0]  rstep_q, rstep_n;
	logic [TYPE_W-1:0] ctype_q, ctype_n;
	logic [LOCAL_TYPES-1:0] tvalid_q, tvalid_n;
	logic [15:0] tmsg_q [LOCAL_TYPES];
	logic [7:0]  tcnt_q [LOCAL_TYPES];
	logic [7:0]  cur_size_q, cur_size_n, cur_num_q, cur_num_n;
	logic [7:0]  num_mem [DEPTH];
	logic [7:0]  size_mem [DEPTH];
	logic [7:0]  rnum_q, rsize_q;
	logic        def_we, num_we, size_we;
	logic [AW-1:0] wa, ra;

	logic        ov_q, out_free, emit;
	kind_t       e_kind;
	err_t        e_err;
	logic [15:0] e_msg;
	logic [7:0]  e_num;
	logic [TYPE_W-1:0] e_lt;
	logic [31:0] e_val;
	logic        e_ok;

	phase_t      ph;
	logic [3:0]  hp;
	logic [15:0] crc_e;
	logic [31:0] dl;
	logic [7:0]  b, size;
	logic        ok, store;

	assign out_free = !ov_q || result.ready;
	assign pop      = q_valid && out_free && phase_q != PH_SKIP;
	assign wa       = slot(ctype_q, fi_q);
	assign ra       = slot(ctype_n, fi_n);

	always_comb begin
		phase_n = phase_q; hpos_n = hpos_q; dlen_n = dlen_q; left_n = left_q;
		acc_n = acc_q; crc_n = crc_q; pmsg_n = pmsg_q; crclo_n = crclo_q;
		fi_n = fi_q; fbi_n = fbi_q; rstep_n = rstep_q; ctype_n = ctype_q;
		tvalid_n = tvalid_q; cur_size_n = cur_size_q; cur_num_n = cur_num_q;
		def_we = 1'b0; num_we = 1'b0; size_we = 1'b0;
		emit = 1'b0; e_kind = KIND_FIELD; e_err = ERR_NONE; e_msg = '0; e_num = '0;
		e_lt = '0; e_val = '0; e_ok = 1'b0;
		b = qd.data; size = cur_size_q; ok = 1'b0; store = 1'b0;
		ph    = qd.start ? PH_HEADER : phase_q;
		hp    = qd.start ? 4'd0 : hpos_q;
		crc_e = qd.start ? 16'd0 : crc_q;
		dl    = qd.start ? 32'd0 : dlen_q;
		if (pop) begin
			phase_n = ph; hpos_n = hp; crc_n = crc_e; dlen_n = dl;
			if (qd.start) tvalid_n = '0;
			unique case (ph)
				PH_HEADER: begin
					if (hp < HDR_CRC_END) crc_n = crc_byte(crc_e, b);
					if (hp[3:2] == 2'd1) dlen_n[8*hp[1:0] +: 8] = b;
					if (hp == HDR_CRC_END) crclo_n = b;
					if (hp >= HDR_LAST) begin
						ok = crc_e == {b, crclo_q};
						emit = 1'b1; e_kind = KIND_HDR; e_ok = ok;
						if (ok) begin
							left_n = dl;
							crc_n = '0;
							phase_n = (dl != '0) ? PH_RECORD : PH_TRAIL_LO;
						end else begin
							phase_n = PH_IDLE;
						end
					end else begin
						hpos_n = hp + 4'd1;
					end
				end
				PH_TRAIL_LO: begin
					crclo_n = b;
					phase_n = PH_TRAIL_HI;
				end
				PH_TRAIL_HI: begin
					emit = 1'b1; e_kind = KIND_FILE; e_ok = crc_q == {b, crclo_q};
					phase_n = PH_IDLE;
				end
				PH_RECORD, PH_DEFINE, PH_FIELD: begin
					crc_n = crc_byte(crc_q, b);
					left_n = left_q - 32'd1;
					if (ph == PH_RECORD) begin
						ctype_n = qd.ltype;
						if (qd.is_def) begin
							rstep_n = '0;
							phase_n = PH_DEFINE;
						end else if (!tvalid_q[qd.ltype]) begin
							emit = 1'b1; e_kind = KIND_ERR; e_err = ERR_UNDEF; e_lt = qd.ltype;
						end else begin
							fi_n = '0; fbi_n = '0; acc_n = '0;
							phase_n = PH_SKIP;
						end
					end else if (ph == PH_DEFINE) begin
						if (rstep_q < 3'd2) begin
							rstep_n = rstep_q + 3'd1;
						end else if (rstep_q == 3'd2) begin
							pmsg_n = {8'h00, b};
							rstep_n = 3'd3;
						end else if (rstep_q == 3'd3) begin
							pmsg_n[15:8] = b;
							rstep_n = 3'd4;
						end else if (rstep_q == 3'd4) begin
							def_we = 1'b1;
							tvalid_n[ctype_q] = {1'b0, b} <= 9'(MAX_FIELDS);
							if ({1'b0, b} > 9'(MAX_FIELDS)) begin
								emit = 1'b1; e_kind = KIND_ERR; e_err = ERR_COUNT;
								e_msg = pmsg_q; e_lt = ctype_q;
							end
							fi_n = '0; fbi_n = '0;
							rstep_n = 3'd5;
							if (b == 8'd0) phase_n = PH_RECORD;
						end else begin
							store = tvalid_q[ctype_q] && ({1'b0, fi_q} < 9'(MAX_FIELDS));
							num_we = store && fbi_q == 8'd0;
							size_we = store && fbi_q == 8'd1;
							if (fbi_q >= 8'd2) begin
								fbi_n = '0;
								fi_n = fi_q + 8'd1;
								if (fi_n >= tcnt_q[ctype_q]) phase_n = PH_RECORD;
							end else begin
								fbi_n = fbi_q + 8'd1;
							end
						end
					end else begin
						if (size <= 8'd4) acc_n[8*fbi_q[1:0] +: 8] = b;
						fbi_n = fbi_q + 8'd1;
						if (fbi_n >= size) begin
							if (size <= 8'd4) begin
								emit = 1'b1; e_kind = KIND_FIELD; e_msg = tmsg_q[ctype_q];
								e_num = cur_num_q; e_lt = ctype_q; e_val = acc_n;
							end
							fi_n = fi_q + 8'd1; fbi_n = '0; acc_n = '0;
							phase_n = PH_SKIP;
						end
					end
					if (left_n == '0) phase_n = PH_TRAIL_LO;
				end
				default: ;
			endcase
		end else if (phase_q == PH_SKIP) begin
			if (fi_q >= tcnt_q[ctype_q]) begin
				phase_n = PH_RECORD;
			end else if (rsize_q == 8'd0) begin
				fi_n = fi_q + 8'd1;
			end else begin
				cur_size_n = rsize_q;
				cur_num_n = rnum_q;
				phase_n = PH_FIELD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; hpos_q <= '0; dlen_q <= '0; left_q <= '0;
			acc_q <= '0; crc_q <= '0; pmsg_q <= '0; crclo_q <= '0; fi_q <= '0;
			fbi_q <= '0; rstep_q <= '0; ctype_q <= '0; tvalid_q <= '0; ov_q <= 1'b0;
		end else begin
			phase_q <= phase_n; hpos_q <= hpos_n; dlen_q <= dlen_n; left_q <= left_n;
			acc_q <= acc_n; crc_q <= crc_n; pmsg_q <= pmsg_n; crclo_q <= crclo_n;
			fi_q <= fi_n; fbi_q <= fbi_n; rstep_q <= rstep_n; ctype_q <= ctype_n;
			tvalid_q <= tvalid_n;
			if (pop && emit) ov_q <= 1'b1;
			else if (result.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_size_q <= cur_size_n;
		cur_num_q <= cur_num_n;
		if (def_we) begin
			tcnt_q[ctype_q] <= b;
			tmsg_q[ctype_q] <= pmsg_q;
		end
		if (num_we) num_mem[wa] <= b;
		if (size_we) size_mem[wa] <= b;
		rnum_q <= num_mem[ra];
		rsize_q <= size_mem[ra];
		if (pop && emit) begin
			result.result_kind    <= e_kind;
			result.message_number <= e_msg;
			result.field_number   <= e_num;
			result.local_type     <= e_lt;
			result.field_value    <= e_val;
			result.check_ok       <= e_ok;
			result.error_code     <= e_err;
		end
	end

	assign result.valid = ov_q;

	a_skip_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> {1'b0, fi_q} <= 9'(MAX_FIELDS))
		else $error("skip index beyond field limit");
	a_field_size: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIELD |-> cur_size_q != 8'd0)
		else $error("zero-size field entered");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(pop))
		else $error("result without consumed item");
	a_skip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |=> $stable(left_q))
		else $error("length moved during skip");

endmodule

@@ rtl/activity_record_stream_parser.sv @@
// Top level of the activity record stream parser: front end, queue, back end.
// Depends on arsp_pkg, arsp_if, arsp_front, arsp_queue, arsp_back.
//
// channel | dir | payload
// item    | in  | data_byte, file_start
// result  | out | result_kind, message_number, field_number, local_type,
//         |     | field_value, check_ok, error_code
//
// One byte per cycle when nothing stalls; a data record header or finished field holds
// the input while the field table memory is read and zero-size fields are passed.
// arst_n clears all control state and the type valid bits at once.
// A result stall halts the back end and, once the queue is full, the input side too.
module activity_record_stream_parser #(
	parameter int MAX_FIELDS = arsp_pkg::DEF_MAX_FIELDS
) (
	input logic           clk,
	input logic           arst_n,
	arsp_item_if.sink     item,
	arsp_result_if.source result
);
	import arsp_pkg::*;

	qitem_t f_data, b_data;
	logic   f_valid, f_ready, b_valid, b_pop;

	arsp_front u_front (
		.clk(clk), .arst_n(arst_n), .item(item),
		.q_data(f_data), .q_valid(f_valid), .q_ready(f_ready)
	);

	arsp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_data(f_data), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(b_data), .rd_valid(b_valid), .rd_ready(b_pop)
	);

	arsp_back #(.MAX_FIELDS(MAX_FIELDS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.qd(b_data), .q_valid(b_valid), .pop(b_pop), .result(result)
	);

endmodule
